// File: src/assert_macros.svh
// Assertion macros used by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define NCC_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define NCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ncc_pkg.sv
// Types, register codes and constants of the nearest centroid classifier.
package ncc_pkg;

	localparam int DEF_MAX_CLUSTERS = 16;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 8;

	localparam logic [CFG_IW-1:0] REG_CLUSTERS = 2'd0;
	localparam logic [CFG_IW-1:0] REG_POWER    = 2'd1;

	localparam logic [4:0] RST_CLUSTERS = 5'd2;
	localparam logic [2:0] RST_POWER    = 3'd2;

	localparam logic [2:0] PW_CHEB = 3'd0;
	localparam logic [2:0] PW_MANH = 3'd1;
	localparam logic [2:0] PW_SQ   = 3'd2;
	localparam logic [2:0] PW_CUBE = 3'd3;
	localparam logic [2:0] PW_4    = 3'd4;
	localparam logic [2:0] PW_5    = 3'd5;
	localparam logic [2:0] PW_6    = 3'd6;
	localparam logic [2:0] PW_7    = 3'd7;

	// Largest magnitude whose power still fits in 64 bits.
	localparam logic [15:0] THR_5 = 16'd7131;
	localparam logic [15:0] THR_6 = 16'd1625;
	localparam logic [15:0] THR_7 = 16'd565;

	localparam logic MODE_LOAD     = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [3:0]        slot;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
	} ncc_req_t;

	typedef struct packed {
		logic [3:0]  nearest_cluster;
		logic [63:0] min_distance;
	} ncc_rsp_t;

	typedef struct packed {
		logic       en;
		logic [2:0] power;
	} ncc_ctl_t;

endpackage

// File: src/nearest_centroid_classifier.sv
// Nearest centroid classifier: one item per clock, with five distance stages per
// centroid lane, then one stage per level of the minimum tree (at least one).
// Load items write a centroid and give no result; a classify item gives one
// result. The whole pipeline stalls while a result waits.

`include "assert_macros.svh"

module nearest_centroid_classifier import ncc_pkg::*; #(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ncc_req_t          req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ncc_rsp_t          rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam int LV    = (MAX_CLUSTERS <= 1) ? 1 : $clog2(MAX_CLUSTERS);
	localparam int DEPTH = 5 + LV;
	localparam int EW    = $clog2(MAX_CLUSTERS + 32);

	logic [31:0]   tbl_q [MAX_CLUSTERS];
	logic [4:0]    clusters_q;
	logic [2:0]    power_q;
	logic [DEPTH-1:0] vld_q;
	logic          adv;
	logic          accept;
	ncc_ctl_t      ctl;
	logic [EW-1:0] eff_cnt;
	logic [EW-1:0] cnt_ext;
	logic [63:0]   lane_dist [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] act;
	logic [LV-1:0] best_idx;
	logic [LV+3:0] idx_ext;
	logic [63:0]   best_dist;

	assign adv       = !vld_q[DEPTH-1] || rsp_ready;
	assign req_ready = adv;
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign ctl.en    = adv;
	assign ctl.power = power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= RST_CLUSTERS;
			power_q    <= RST_POWER;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CLUSTERS: clusters_q <= cfg_data[4:0];
				REG_POWER:    power_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_CLUSTERS; j++) begin
				tbl_q[j] <= '0;
			end
		end else if (accept && req.mode == MODE_LOAD) begin
			for (int j = 0; j < MAX_CLUSTERS; j++) begin
				if (EW'(req.slot) == EW'(j)) begin
					tbl_q[j] <= {req.coord_y, req.coord_x};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], accept && req.mode != MODE_LOAD};
		end
	end

	assign cnt_ext = EW'(clusters_q);

	always_comb begin
		if (cnt_ext == '0) begin
			eff_cnt = EW'(1);
		end else if (cnt_ext > EW'(MAX_CLUSTERS)) begin
			eff_cnt = EW'(MAX_CLUSTERS);
		end else begin
			eff_cnt = cnt_ext;
		end
		for (int j = 0; j < MAX_CLUSTERS; j++) begin
			act[j] = EW'(j) < eff_cnt;
		end
	end

	for (genvar j = 0; j < MAX_CLUSTERS; j++) begin : g_lane
		ncc_dist u_dist (
			.clk     (clk),
			.ctl     (ctl),
			.samp_x  (req.coord_x),
			.samp_y  (req.coord_y),
			.cen_x   (tbl_q[j][15:0]),
			.cen_y   (tbl_q[j][31:16]),
			.measure (lane_dist[j])
		);
	end

	ncc_argmin #(
		.N (MAX_CLUSTERS)
	) u_argmin (
		.clk       (clk),
		.en        (adv),
		.dists     (lane_dist),
		.act       (act),
		.best_idx  (best_idx),
		.best_dist (best_dist)
	);

	assign idx_ext             = {4'b0, best_idx};
	assign rsp_valid           = vld_q[DEPTH-1];
	assign rsp.nearest_cluster = idx_ext[3:0];
	assign rsp.min_distance    = best_dist;

	`NCC_ASSERT_NOW(a_stall_blocks_input, rsp_valid && !rsp_ready, !req_ready, "input taken during a stalled result")
	`NCC_ASSERT(a_count_range, (eff_cnt != '0) && (eff_cnt <= EW'(MAX_CLUSTERS)), "active centroid count out of range")
	`NCC_ASSERT_NOW(a_linear_metric_small, rsp_valid && (power_q == PW_CHEB || power_q == PW_MANH), rsp.min_distance[63:17] == '0, "linear metric distance too wide")

endmodule

// File: src/ncc_dist.sv
// Five-stage distance unit that measures a sample against one centroid.
module ncc_dist import ncc_pkg::*; (
	input  logic               clk,
	input  ncc_ctl_t           ctl,
	input  logic signed [15:0] samp_x,
	input  logic signed [15:0] samp_y,
	input  logic signed [15:0] cen_x,
	input  logic signed [15:0] cen_y,
	output logic [63:0]        measure
);

	logic signed [15:0] sa [2];
	logic signed [15:0] ca [2];
	logic signed [16:0] diff [2];
	logic [15:0]        mag [2];

	logic [15:0] d_s1 [2];
	logic [15:0] d_s2 [2];
	logic [31:0] sq_s2 [2];
	logic [15:0] d_s3 [2];
	logic [31:0] sq_s3 [2];
	logic [47:0] cu_s3 [2];
	logic [63:0] qd_s3 [2];
	logic [63:0] m5 [2];
	logic [63:0] m6 [2];
	logic [63:0] m7 [2];
	logic [63:0] val [2];
	logic        ovf [2];
	logic [63:0] pw_s4 [2];
	logic [64:0] sum;
	logic [63:0] dist_s5;

	assign sa[0] = samp_x;
	assign sa[1] = samp_y;
	assign ca[0] = cen_x;
	assign ca[1] = cen_y;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			diff[k] = {sa[k][15], sa[k]} - {ca[k][15], ca[k]};
			mag[k]  = diff[k][16] ? 16'(-diff[k]) : diff[k][15:0];
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			m5[k] = 64'(qd_s3[k][51:0]) * 64'(d_s3[k][12:0]);
			m6[k] = 64'(qd_s3[k][43:0]) * 64'(sq_s3[k][21:0]);
			m7[k] = 64'(qd_s3[k][36:0]) * 64'(cu_s3[k][27:0]);
			ovf[k] = 1'b0;
			case (ctl.power) inside
				PW_CHEB, PW_MANH: val[k] = 64'(d_s3[k]);
				PW_SQ:            val[k] = 64'(sq_s3[k]);
				PW_CUBE:          val[k] = 64'(cu_s3[k]);
				PW_4:             val[k] = qd_s3[k];
				PW_5: begin
					val[k] = m5[k];
					ovf[k] = d_s3[k] > THR_5;
				end
				PW_6: begin
					val[k] = m6[k];
					ovf[k] = d_s3[k] > THR_6;
				end
				default: begin
					val[k] = m7[k];
					ovf[k] = d_s3[k] > THR_7;
				end
			endcase
		end
	end

	assign sum = {1'b0, pw_s4[0]} + {1'b0, pw_s4[1]};

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < 2; k++) begin
				d_s1[k]  <= mag[k];
				d_s2[k]  <= d_s1[k];
				sq_s2[k] <= 32'(d_s1[k]) * 32'(d_s1[k]);
				d_s3[k]  <= d_s2[k];
				sq_s3[k] <= sq_s2[k];
				cu_s3[k] <= 48'(sq_s2[k]) * 48'(d_s2[k]);
				qd_s3[k] <= 64'(sq_s2[k]) * 64'(sq_s2[k]);
				pw_s4[k] <= ovf[k] ? '1 : val[k];
			end
			case (ctl.power)
				PW_CHEB: dist_s5 <= (pw_s4[0] > pw_s4[1]) ? pw_s4[0] : pw_s4[1];
				default: dist_s5 <= sum[64] ? '1 : sum[63:0];
			endcase
		end
	end

	assign measure = dist_s5;

endmodule

// File: src/ncc_argmin.sv
// Registered comparison tree that finds the lowest-index minimum distance.
module ncc_argmin import ncc_pkg::*; #(
	parameter int N = DEF_MAX_CLUSTERS
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [63:0]                          dists [N],
	input  logic [N-1:0]                         act,
	output logic [((N <= 1) ? 1 : $clog2(N))-1:0] best_idx,
	output logic [63:0]                          best_dist
);

	localparam int LV   = (N <= 1) ? 1 : $clog2(N);
	localparam int NPAD = 1 << LV;

	logic [63:0]   all_d [2*NPAD];
	logic [LV-1:0] all_i [2*NPAD];
	logic          all_a [2*NPAD];
	logic [63:0]   tr_d [NPAD];
	logic [LV-1:0] tr_i [NPAD];
	logic          tr_a [NPAD];
	logic          take_r [NPAD];

	always_comb begin
		for (int i = 0; i < NPAD; i++) begin
			all_d[i] = tr_d[i];
			all_i[i] = tr_i[i];
			all_a[i] = tr_a[i];
		end
		for (int j = 0; j < NPAD; j++) begin
			if (j < N) begin
				all_d[NPAD+j] = dists[j];
				all_a[NPAD+j] = act[j];
			end else begin
				all_d[NPAD+j] = '1;
				all_a[NPAD+j] = 1'b0;
			end
			all_i[NPAD+j] = LV'(j);
		end
		for (int i = 0; i < NPAD; i++) begin
			take_r[i] = all_a[2*i+1] && (!all_a[2*i] || (all_d[2*i+1] < all_d[2*i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 1; i < NPAD; i++) begin
				tr_d[i] <= take_r[i] ? all_d[2*i+1] : all_d[2*i];
				tr_i[i] <= take_r[i] ? all_i[2*i+1] : all_i[2*i];
				tr_a[i] <= all_a[2*i] | all_a[2*i+1];
			end
			tr_d[0] <= all_d[1];
			tr_i[0] <= all_i[1];
			tr_a[0] <= all_a[1];
		end
	end

	assign best_idx  = tr_i[1];
	assign best_dist = tr_d[1];

endmodule

// File: test/testbench.sv
// Self-checking testbench for the nearest centroid classifier.
`timescale 1ns / 1ps

module testbench;
	import ncc_pkg::*;

	localparam int SETTLE_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [63:0] DIST_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ncc_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b1;
	ncc_rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = REG_CLUSTERS;
	logic [CFG_DW-1:0] cfg_data = '0;

	logic [31:0] centroids [DEF_MAX_CLUSTERS];
	logic [4:0] active_clusters = RST_CLUSTERS;
	logic [2:0] metric_power = RST_POWER;
	ncc_rsp_t expected_results [$];

	bit busy_sender = 1'b0;
	bit busy_receiver = 1'b0;
	int rsp_wait = 0;
	int failures = 0;
	int loads_sent = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int quiet_cycles = 0;

	nearest_centroid_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] power_sat(logic [63:0] base, int p);
		logic [127:0] acc;
		acc = 128'd1;
		for (int i = 0; i < p; i++) begin
			acc = acc * base;
			if (acc > DIST_MAX)
				acc = DIST_MAX;
		end
		return acc[63:0];
	endfunction

	function automatic logic [63:0] centroid_distance(logic [63:0] ax, logic [63:0] ay);
		logic [64:0] total;
		case (metric_power)
			PW_CHEB: begin
				return (ax > ay) ? ax : ay;
			end
			PW_MANH: begin
				return ax + ay;
			end
			default: begin
				total = power_sat(ax, metric_power) + power_sat(ay, metric_power);
				return total[64] ? DIST_MAX : total[63:0];
			end
		endcase
	endfunction

	function automatic ncc_rsp_t nearest_centroid(ncc_req_t it);
		ncc_rsp_t best;
		int count;
		int dx;
		int dy;
		logic [63:0] d;
		count = (active_clusters == 0) ? 1 :
			(active_clusters > DEF_MAX_CLUSTERS) ? DEF_MAX_CLUSTERS : active_clusters;
		best = '0;
		for (int j = 0; j < count; j++) begin
			dx = int'(it.coord_x) - int'($signed(centroids[j][15:0]));
			dy = int'(it.coord_y) - int'($signed(centroids[j][31:16]));
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			d = centroid_distance(64'(dx), 64'(dy));
			if (j == 0 || d < best.min_distance) begin
				best.nearest_cluster = j[3:0];
				best.min_distance = d;
			end
		end
		return best;
	endfunction

	task automatic send_item(logic mode, logic [3:0] slot, logic [15:0] x, logic [15:0] y);
		ncc_req_t it;
		int gap;
		it.mode = mode;
		it.slot = slot;
		it.coord_x = x;
		it.coord_y = y;
		gap = busy_sender ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (it.mode == MODE_LOAD) begin
			centroids[it.slot] = {it.coord_y, it.coord_x};
			loads_sent++;
		end else begin
			expected_results.insert(expected_results.size(), nearest_centroid(it));
			samples_sent++;
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (index == REG_CLUSTERS)
			active_clusters = data[4:0];
		else if (index == REG_POWER)
			metric_power = data[2:0];
	endtask

	function automatic logic [15:0] random_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 1200) - 600);
			1: return 16'($urandom_range(0, 16000) - 8000);
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset_state();
		send_item(MODE_CLASSIFY, 4'h0, 16'h0000, 16'h0000);
		send_item(MODE_CLASSIFY, 4'hF, 16'h7FFF, 16'h7FFF);
		send_item(MODE_CLASSIFY, 4'hA, 16'h8000, 16'h8000);
	endtask

	task automatic test_directed();
		write_register(REG_CLUSTERS, 8'd16);
		send_item(MODE_LOAD, 4'h0, 16'h7FFF, 16'h8000);
		send_item(MODE_LOAD, 4'h1, 16'h8000, 16'h7FFF);
		send_item(MODE_LOAD, 4'h5, 16'h0010, 16'h0010);
		send_item(MODE_LOAD, 4'h6, 16'h0010, 16'h0010);
		send_item(MODE_LOAD, 4'hF, 16'hFFFF, 16'h0001);
		for (int p = 0; p < 8; p++) begin
			write_register(REG_POWER, 8'(p));
			send_item(MODE_CLASSIFY, 4'h3, 16'h8000, 16'h7FFF);
			send_item(MODE_CLASSIFY, 4'hC, 16'h0011, 16'h000F);
		end
		write_register(REG_CLUSTERS, 8'd0);
		send_item(MODE_CLASSIFY, 4'h0, 16'h0000, 16'h0000);
		write_register(REG_CLUSTERS, 8'hFF);
		send_item(MODE_CLASSIFY, 4'h0, 16'hFFFF, 16'h0001);
		write_register(REG_CLUSTERS, 8'd1);
		send_item(MODE_CLASSIFY, 4'h9, 16'h7FFF, 16'h7FFF);
	endtask

	task automatic test_random_phases();
		int n;
		for (int phase = 0; phase < 12; phase++) begin
			write_register(REG_CLUSTERS, (phase % 4 == 0) ? 8'd16 : 8'($urandom_range(0, 255)));
			write_register(REG_POWER, (phase % 5 == 0) ? 8'd7 : 8'($urandom_range(0, 255)));
			busy_sender = (phase % 3 == 2);
			busy_receiver = (phase % 4 == 3);
			n = $urandom_range(2, 8);
			for (int k = 0; k < n; k++)
				send_item(MODE_LOAD, 4'($urandom), random_coord(), random_coord());
			for (int k = 0; k < 32; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_item(MODE_LOAD, 4'($urandom), random_coord(), random_coord());
				else
					send_item(MODE_CLASSIFY, 4'($urandom), random_coord(), random_coord());
			end
		end
		busy_sender = 1'b0;
		busy_receiver = 1'b0;
	endtask

	task automatic test_sender_pause();
		for (int k = 0; k < 10; k++)
			send_item(MODE_CLASSIFY, 4'($urandom), random_coord(), random_coord());
		drain();
		for (int k = 0; k < 10; k++)
			send_item(k[0], 4'($urandom), random_coord(), random_coord());
	endtask

	always @(posedge clk) begin
		ncc_rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: cluster %0d distance %0d",
					rsp.nearest_cluster, rsp.min_distance);
				failures++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (rsp.nearest_cluster !== want.nearest_cluster) begin
					$error("nearest_cluster: expected %0d, got %0d",
						want.nearest_cluster, rsp.nearest_cluster);
					failures++;
				end
				if (rsp.min_distance !== want.min_distance) begin
					$error("min_distance: expected %0d, got %0d",
						want.min_distance, rsp.min_distance);
					failures++;
				end
			end
			rsp_wait = busy_receiver ? 0 : $urandom_range(0, 15);
		end
		if (rsp_wait > 0) begin
			rsp_wait--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("nearest_centroid_classifier regression: fail");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < DEF_MAX_CLUSTERS; i++)
			centroids[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_random_phases();
		test_sender_pause();
		drain();
		$display("Covered %0d centroid loads and %0d classified samples over all metrics.",
			loads_sent, samples_sent);
		$display("Checked %0d results, %0d mismatches.", results_checked, failures);
		if (failures == 0)
			$display("nearest_centroid_classifier regression: pass");
		else
			$display("nearest_centroid_classifier regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/ncc_pkg.sv
src/ncc_dist.sv
src/ncc_argmin.sv
src/nearest_centroid_classifier.sv
test/testbench.sv
